/* design/tcr_pkg.sv */
// Shared types and constants for the text console renderer.
// Holds the item structs, command and register codes, FSM state and
// controller/datapath command and status bundles. No dependencies.
package tcr_pkg;

  localparam int DEF_MAX_COLUMNS      = 128;
  localparam int DEF_MAX_ROWS         = 64;
  localparam int DEF_FAST_BLINK_TICKS = 250;
  localparam int DEF_SLOW_BLINK_TICKS = 500;

  // command codes
  localparam logic [3:0] CMD_PUT_CURSOR  = 4'd0;
  localparam logic [3:0] CMD_PUT_AT      = 4'd1;
  localparam logic [3:0] CMD_MOVE        = 4'd2;
  localparam logic [3:0] CMD_RENDER      = 4'd3;
  localparam logic [3:0] CMD_FONT        = 4'd4;
  localparam logic [3:0] CMD_PALETTE     = 4'd5;
  localparam logic [3:0] CMD_TICK        = 4'd6;
  localparam logic [3:0] CMD_CLEAR       = 4'd7;
  localparam logic [3:0] CMD_SCROLL_UP   = 4'd8;
  localparam logic [3:0] CMD_SCROLL_DOWN = 4'd9;

  // configuration register indexes
  localparam logic [2:0] CFG_COLUMNS    = 3'd0;
  localparam logic [2:0] CFG_ROWS       = 3'd1;
  localparam logic [2:0] CFG_CUR_SHAPE  = 3'd2;
  localparam logic [2:0] CFG_CUR_BLINK  = 3'd3;
  localparam logic [2:0] CFG_WR_FG      = 3'd4;
  localparam logic [2:0] CFG_WR_BG      = 3'd5;
  localparam logic [2:0] CFG_WR_ATTR    = 3'd6;

  localparam logic [1:0] CUR_OFF    = 2'd0;
  localparam logic [1:0] CUR_BLOCK  = 2'd1;
  localparam logic [1:0] CUR_RIGHT  = 2'd2;
  localparam logic [1:0] CUR_BOTTOM = 2'd3;

  localparam logic [1:0] BLINK_STEADY = 2'd0;
  localparam logic [1:0] BLINK_FAST   = 2'd1;
  localparam logic [1:0] BLINK_SLOW   = 2'd2;

  localparam int ATTR_BLINK_BIT   = 0;
  localparam int ATTR_REVERSE_BIT = 1;
  localparam int ATTR_TRANSP_BIT  = 2;
  localparam int ATTR_ULINE_BIT   = 3;

  localparam logic [19:0] BLANK_CELL = 20'h40F00;

  localparam logic [7:0] RST_COLUMNS = 8'd80;
  localparam logic [6:0] RST_ROWS    = 7'd60;
  localparam logic [3:0] RST_WR_FG   = 4'd15;

  typedef struct packed {
    logic [3:0]  command;
    logic [7:0]  char_code;
    logic [5:0]  text_row;
    logic [6:0]  text_col;
    logic [2:0]  char_line;
    logic [10:0] table_index;
    logic [15:0] table_data;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pixel_color;
    logic        opaque;
    logic        last_pixel;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_MCLR,
    ST_IDLE,
    ST_RND_CELL,
    ST_RND_OUT,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_FILL_ROW,
    ST_FILL_ALL
  } state_t;

  typedef struct packed {
    logic accept;
    logic mclr_step;
    logic rnd_fetch;
    logic out_beat;
    logic copy_rd;
    logic copy_wr;
    logic fill_wr;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mclr_last;
    logic col_last;
    logic copy_row_last;
    logic no_copy;
    logic fill_row_last;
    logic pix_last;
  } ctrl_sts_t;

endpackage

/* design/text_console_renderer.sv */
// Text console renderer: a cell store of MAX_ROWS x MAX_COLUMNS cells, an
// 8x8 font and a 16-colour palette. After reset the block sweeps the cell
// store to blank cells, one cell a clock, and takes no command meanwhile.
// A render reads the cell, then looks up font and palette, and then gives
// eight output beats, one a clock while out_ready is high. Clear and the
// blank row of a scroll write one cell a clock; the scroll copy goes through
// the single cell-store read port, reading and then writing each cell.
// Configuration writes are taken every cycle. Depends on tcr_pkg, tcr_ctrl
// and tcr_dp.
module text_console_renderer
  import tcr_pkg::*;
#(
  parameter int MAX_COLUMNS      = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS         = DEF_MAX_ROWS,
  parameter int FAST_BLINK_TICKS = DEF_FAST_BLINK_TICKS,
  parameter int SLOW_BLINK_TICKS = DEF_SLOW_BLINK_TICKS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  assign cfg_ready = 1'b1;

  tcr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_data.command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  tcr_dp #(
    .MAX_COLUMNS      (MAX_COLUMNS),
    .MAX_ROWS         (MAX_ROWS),
    .FAST_BLINK_TICKS (FAST_BLINK_TICKS),
    .SLOW_BLINK_TICKS (SLOW_BLINK_TICKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a pixel beat is pending");

  a_render_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.command == CMD_RENDER) |-> ##2 out_valid)
    else $error("render did not reach the output in two cycles");

  a_last_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.last_pixel) |=> (!out_valid && in_ready))
    else $error("pixel beats continued past the last pixel");
`endif

endmodule

/* design/tcr_ctrl.sv */
// Controller FSM for the text console renderer.
// Sequences memory clear, render, clear and scroll; depends on tcr_pkg.
module tcr_ctrl
  import tcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [3:0] in_command,
  output logic       out_valid,
  input  logic       out_ready,
  input  ctrl_sts_t  sts,
  output ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_MCLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_MCLR: begin
        if (sts.mclr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          priority case (in_command)
            CMD_RENDER: state_nxt = ST_RND_CELL;
            CMD_CLEAR:  state_nxt = ST_FILL_ALL;
            CMD_SCROLL_UP, CMD_SCROLL_DOWN: begin
              state_nxt = sts.no_copy ? ST_FILL_ROW : ST_COPY_RD;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RND_CELL: state_nxt = ST_RND_OUT;
      ST_RND_OUT: begin
        if (out_ready && sts.pix_last) state_nxt = ST_IDLE;
      end
      ST_COPY_RD: state_nxt = ST_COPY_WR;
      ST_COPY_WR: begin
        if (sts.col_last && sts.copy_row_last) state_nxt = ST_FILL_ROW;
        else state_nxt = ST_COPY_RD;
      end
      ST_FILL_ROW: begin
        if (sts.col_last) state_nxt = ST_IDLE;
      end
      ST_FILL_ALL: begin
        if (sts.col_last && sts.fill_row_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_MCLR;
    endcase
  end

  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    out_valid     = (state_r == ST_RND_OUT);
    cmd.accept    = in_ready && in_valid;
    cmd.mclr_step = (state_r == ST_MCLR);
    cmd.rnd_fetch = (state_r == ST_RND_CELL);
    cmd.out_beat  = out_valid && out_ready;
    cmd.copy_rd   = (state_r == ST_COPY_RD);
    cmd.copy_wr   = (state_r == ST_COPY_WR);
    cmd.fill_wr   = (state_r == ST_FILL_ROW) || (state_r == ST_FILL_ALL);
  end

endmodule

/* design/tcr_dp.sv */
// Datapath for the text console renderer: config registers, cursor, blink
// timers, cell/font/palette memories, loop counters and pixel stage.
// Depends on tcr_pkg; driven by tcr_ctrl.
module tcr_dp
  import tcr_pkg::*;
#(
  parameter int MAX_COLUMNS      = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS         = DEF_MAX_ROWS,
  parameter int FAST_BLINK_TICKS = DEF_FAST_BLINK_TICKS,
  parameter int SLOW_BLINK_TICKS = DEF_SLOW_BLINK_TICKS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_data,
  input  logic       cfg_valid,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  ctrl_cmd_t  cmd,
  output ctrl_sts_t  sts,
  output out_item_t  out_data
);

  localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam logic [8:0]    MAX_COLS_W = 9'(MAX_COLUMNS);
  localparam logic [8:0]    MAX_ROWS_W = 9'(MAX_ROWS);
  localparam logic [AW-1:0] LAST_ADDR  = AW'(CELLS - 1);

  function automatic logic [AW-1:0] cell_addr(input logic [6:0] row, input logic [7:0] col);
    cell_addr = AW'(int'(row) * MAX_COLUMNS + int'(col));
  endfunction

  // configuration
  logic [7:0] cols_cfg_r;
  logic [6:0] rows_cfg_r;
  logic [1:0] shape_r, bmode_r;
  logic [3:0] wfg_r, wbg_r, wattr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_cfg_r <= RST_COLUMNS;
      rows_cfg_r <= RST_ROWS;
      shape_r    <= CUR_OFF;
      bmode_r    <= BLINK_STEADY;
      wfg_r      <= RST_WR_FG;
      wbg_r      <= '0;
      wattr_r    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_COLUMNS:   cols_cfg_r <= cfg_data;
        CFG_ROWS:      rows_cfg_r <= cfg_data[6:0];
        CFG_CUR_SHAPE: shape_r    <= cfg_data[1:0];
        CFG_CUR_BLINK: bmode_r    <= cfg_data[1:0];
        CFG_WR_FG:     wfg_r      <= cfg_data[3:0];
        CFG_WR_BG:     wbg_r      <= cfg_data[3:0];
        CFG_WR_ATTR:   wattr_r    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  logic [7:0] cols;
  logic [6:0] rows;

  always_comb begin
    if (cols_cfg_r == '0) cols = 8'd1;
    else if ({1'b0, cols_cfg_r} > MAX_COLS_W) cols = MAX_COLS_W[7:0];
    else cols = cols_cfg_r;
    if (rows_cfg_r == '0) rows = 7'd1;
    else if ({2'b0, rows_cfg_r} > MAX_ROWS_W) rows = MAX_ROWS_W[6:0];
    else rows = rows_cfg_r;
  end

  logic [6:0]  in_row;
  logic [7:0]  in_col;
  logic [19:0] new_cell;
  logic        is_acc;

  assign in_row   = {1'b0, in_data.text_row};
  assign in_col   = {1'b0, in_data.text_col};
  assign new_cell = {wattr_r, wbg_r, wfg_r, in_data.char_code};
  assign is_acc   = cmd.accept;

  // cursor
  logic [6:0] curs_row_r;
  logic [7:0] curs_col_r;
  logic       curs_in;
  logic [8:0] col_inc;
  logic [7:0] row_inc;

  assign curs_in = (curs_row_r < rows) && (curs_col_r < cols);
  assign col_inc = {1'b0, curs_col_r} + 9'd1;
  assign row_inc = {1'b0, curs_row_r} + 8'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curs_row_r <= '0;
      curs_col_r <= '0;
    end else if (is_acc && in_data.command == CMD_PUT_CURSOR) begin
      if (col_inc >= {1'b0, cols}) begin
        curs_col_r <= '0;
        curs_row_r <= (row_inc >= {1'b0, rows}) ? 7'd0 : row_inc[6:0];
      end else begin
        curs_col_r <= col_inc[7:0];
      end
    end else if (is_acc && in_data.command == CMD_MOVE) begin
      curs_col_r <= (in_col >= cols) ? cols - 8'd1 : in_col;
      curs_row_r <= (in_row >= rows) ? rows - 7'd1 : in_row;
    end
  end

  // blink timers
  logic [15:0] fast_cnt_r, slow_cnt_r;
  logic        fast_phase_r, slow_phase_r;
  logic [16:0] fast_sum, slow_sum;

  assign fast_sum = {1'b0, fast_cnt_r} + 17'd1;
  assign slow_sum = {1'b0, slow_cnt_r} + 17'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_cnt_r   <= '0;
      slow_cnt_r   <= '0;
      fast_phase_r <= 1'b0;
      slow_phase_r <= 1'b0;
    end else if (is_acc && in_data.command == CMD_TICK) begin
      if (fast_sum >= 17'(FAST_BLINK_TICKS)) begin
        fast_cnt_r   <= '0;
        fast_phase_r <= ~fast_phase_r;
      end else begin
        fast_cnt_r <= fast_sum[15:0];
      end
      if (slow_sum >= 17'(SLOW_BLINK_TICKS)) begin
        slow_cnt_r   <= '0;
        slow_phase_r <= ~slow_phase_r;
      end else begin
        slow_cnt_r <= slow_sum[15:0];
      end
    end
  end

  // clear / scroll loop counters
  logic [6:0]    lp_row_r;
  logic [7:0]    lp_col_r;
  logic          lp_down_r;
  logic [AW-1:0] mclr_cnt_r;
  logic [6:0]    src_row;
  logic          lp_start;
  logic [2:0]    pix_idx_r;

  assign src_row  = lp_down_r ? lp_row_r - 7'd1 : lp_row_r + 7'd1;
  assign lp_start = is_acc && (in_data.command == CMD_CLEAR ||
                               in_data.command == CMD_SCROLL_UP ||
                               in_data.command == CMD_SCROLL_DOWN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_row_r   <= '0;
      lp_col_r   <= '0;
      lp_down_r  <= 1'b0;
      mclr_cnt_r <= '0;
    end else begin
      if (cmd.mclr_step) mclr_cnt_r <= mclr_cnt_r + AW'(1);
      if (lp_start) begin
        lp_col_r  <= '0;
        lp_down_r <= (in_data.command == CMD_SCROLL_DOWN);
        lp_row_r  <= (in_data.command == CMD_SCROLL_DOWN) ? rows - 7'd1 : 7'd0;
      end else if (cmd.copy_wr || cmd.fill_wr) begin
        if (sts.col_last) begin
          lp_col_r <= '0;
          // scroll down copies walk upwards; fills always walk down
          lp_row_r <= (cmd.copy_wr && lp_down_r) ? lp_row_r - 7'd1 : lp_row_r + 7'd1;
        end else begin
          lp_col_r <= lp_col_r + 8'd1;
        end
      end
    end
  end

  always_comb begin
    sts.mclr_last     = (mclr_cnt_r == LAST_ADDR);
    sts.col_last      = (lp_col_r == cols - 8'd1);
    sts.copy_row_last = lp_down_r ? (lp_row_r == 7'd1) : (lp_row_r == rows - 7'd2);
    sts.no_copy       = (rows == 7'd1);
    sts.fill_row_last = (lp_row_r == rows - 7'd1);
    sts.pix_last      = (pix_idx_r == 3'd7);
  end

  // cell store: one write port, one registered read port
  logic [19:0]   cell_mem [CELLS];
  logic [19:0]   cell_q;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [19:0]   wr_data;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cell_addr(lp_row_r, lp_col_r);
    wr_data = BLANK_CELL;
    priority if (cmd.mclr_step) begin
      wr_en   = 1'b1;
      wr_addr = mclr_cnt_r;
    end else if (cmd.copy_wr) begin
      wr_en   = 1'b1;
      wr_data = cell_q;
    end else if (cmd.fill_wr) begin
      wr_en = 1'b1;
    end else if (is_acc && in_data.command == CMD_PUT_CURSOR) begin
      wr_en   = curs_in;
      wr_addr = cell_addr(curs_row_r, curs_col_r);
      wr_data = new_cell;
    end else if (is_acc && in_data.command == CMD_PUT_AT) begin
      wr_en   = (in_row < rows) && (in_col < cols);
      wr_addr = cell_addr(in_row, in_col);
      wr_data = new_cell;
    end
  end

  assign rd_en   = cmd.copy_rd || is_acc;
  assign rd_addr = cmd.copy_rd ? cell_addr(src_row, lp_col_r) : cell_addr(in_row, in_col);

  always_ff @(posedge clk) begin
    if (wr_en) cell_mem[wr_addr] <= wr_data;
    if (rd_en) cell_q <= cell_mem[rd_addr];
  end

  // render fetch
  in_item_t   in_r;
  logic       r_in_range, row_hit, visible;
  logic [19:0] rcell;

  always_ff @(posedge clk) begin
    if (is_acc) in_r <= in_data;
  end

  assign r_in_range = ({1'b0, in_r.text_row} < rows) && ({1'b0, in_r.text_col} < cols);
  assign rcell      = r_in_range ? cell_q : '0;
  assign row_hit    = (shape_r != CUR_OFF) && ({1'b0, in_r.text_row} == curs_row_r);

  always_comb begin
    unique case (bmode_r)
      BLINK_STEADY: visible = row_hit;
      BLINK_FAST:   visible = row_hit && fast_phase_r;
      BLINK_SLOW:   visible = row_hit && slow_phase_r;
      default:      visible = 1'b0;
    endcase
  end

  logic [7:0]  font_mem [2048];
  logic [15:0] pal_mem [16];
  logic [7:0]  font_q;
  logic [15:0] fg_q, bg_q;

  always_ff @(posedge clk) begin
    if (is_acc && in_data.command == CMD_FONT)
      font_mem[in_data.table_index] <= in_data.table_data[7:0];
    if (cmd.rnd_fetch) font_q <= font_mem[{in_r.char_line, rcell[7:0]}];
  end

  always_ff @(posedge clk) begin
    if (is_acc && in_data.command == CMD_PALETTE && in_data.table_index[10:4] == '0)
      pal_mem[in_data.table_index[3:0]] <= in_data.table_data;
    if (cmd.rnd_fetch) begin
      fg_q <= pal_mem[rcell[11:8]];
      bg_q <= pal_mem[rcell[15:12]];
    end
  end

  logic rf_in_range_r, rf_cur_hit_r, rf_blink_r, rf_uline_r;
  logic rf_transp_r, rf_rev_r, rf_line7_r;

  always_ff @(posedge clk) begin
    if (cmd.rnd_fetch) begin
      rf_in_range_r <= r_in_range;
      rf_cur_hit_r  <= visible && ({1'b0, in_r.text_col} == curs_col_r);
      rf_blink_r    <= rcell[16 + ATTR_BLINK_BIT] && fast_phase_r;
      rf_uline_r    <= rcell[16 + ATTR_ULINE_BIT] && (in_r.char_line == 3'd7);
      rf_transp_r   <= rcell[16 + ATTR_TRANSP_BIT];
      rf_rev_r      <= rcell[16 + ATTR_REVERSE_BIT];
      rf_line7_r    <= (in_r.char_line == 3'd7);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_idx_r <= '0;
    end else if (cmd.rnd_fetch) begin
      pix_idx_r <= '0;
    end else if (cmd.out_beat) begin
      pix_idx_r <= pix_idx_r + 3'd1;
    end
  end

  // pixel stage
  logic [7:0] pix;
  logic       bit_on;

  always_comb begin
    pix = font_q;
    if (rf_cur_hit_r) begin
      unique case (shape_r)
        CUR_BLOCK:  pix = ~font_q;
        CUR_RIGHT:  pix = font_q | 8'h01;
        CUR_BOTTOM: pix = rf_line7_r ? 8'hff : font_q;
        default:    pix = font_q;
      endcase
    end else if (rf_blink_r) begin
      pix = ~font_q;
    end
    bit_on = rf_uline_r || pix[3'd7 - pix_idx_r];

    out_data.pixel_color = '0;
    out_data.opaque      = 1'b0;
    out_data.last_pixel  = sts.pix_last;
    if (!rf_in_range_r) begin
      out_data.opaque = 1'b0;
    end else if (rf_transp_r) begin
      if (rf_rev_r && !bit_on) begin
        out_data.pixel_color = bg_q;
        out_data.opaque      = 1'b1;
      end else if (!rf_rev_r && bit_on) begin
        out_data.pixel_color = fg_q;
        out_data.opaque      = 1'b1;
      end
    end else begin
      out_data.opaque      = 1'b1;
      out_data.pixel_color = (bit_on ^ rf_rev_r) ? fg_q : bg_q;
    end
  end

endmodule

/* sim/tb_text_console_renderer.sv */
// Self-checking testbench for text_console_renderer: a queue-fed driver, an
// output monitor and a built-in predictor of the cell, font and palette stores.
// Depends on tcr_pkg and the design files only.
module tb_text_console_renderer;
  import tcr_pkg::*;

  localparam int NCOLS = DEF_MAX_COLUMNS;
  localparam int NROWS = DEF_MAX_ROWS;
  localparam int WATCHDOG = 60000;
  localparam int SETTLE_BULK = 17000; // full-area scroll copy plus margin
  localparam int SETTLE_SHORT = 40;

  typedef enum int {JOB_ITEM, JOB_CFG, JOB_DRAIN} job_kind_t;
  typedef struct {
    job_kind_t   kind;
    in_item_t    item;
    logic [2:0]  reg_idx;
    logic [7:0]  reg_val;
  } job_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  text_console_renderer DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predicted console state
  logic [19:0] cells [NCOLS*NROWS];
  logic [7:0]  glyphs [2048];
  logic [15:0] colours [16];
  int cur_row, cur_col, fast_cnt, slow_cnt;
  bit fast_ph, slow_ph;
  logic [7:0] r_cols;
  logic [6:0] r_rows;
  logic [1:0] r_shape, r_blink;
  logic [3:0] r_fg, r_bg, r_attr;

  job_t jobs[$];
  out_item_t pixels_due[$];
  logic [7:0] char_set [3] = '{8'h00, 8'hFF, 8'h5A};

  int errors = 0, n_items = 0, n_pixels = 0, n_cfg = 0, idle_cnt = 0;
  int quiet = 0, settle = SETTLE_SHORT, cyc = 0;
  bit in_acc = 0, cfg_acc = 0;
  wire calm = ((cyc / 3000) % 4) == 2; // stretches with no idling

  function automatic int used_cols();
    if (r_cols == 0) return 1;
    return (r_cols > NCOLS) ? NCOLS : int'(r_cols);
  endfunction

  function automatic int used_rows();
    if (r_rows == 0) return 1;
    return (r_rows > NROWS) ? NROWS : int'(r_rows);
  endfunction

  function automatic void render_slice(in_item_t it);
    int rw, cl, ln;
    bit in_range, row_hit, vis, uline, blk, transp, rev, b;
    logic [19:0] cval;
    logic [7:0] pix;
    logic [15:0] fgc, bgc;
    logic [3:0] at;
    out_item_t o;
    rw = it.text_row; cl = it.text_col; ln = it.char_line;
    in_range = rw < used_rows() && cl < used_cols();
    cval = in_range ? cells[rw*NCOLS + cl] : 20'h0;
    fgc = colours[cval[11:8]];
    bgc = colours[cval[15:12]];
    at = cval[19:16];
    pix = glyphs[{it.char_line, cval[7:0]}];
    row_hit = r_shape != CUR_OFF && rw == cur_row;
    case (r_blink)
      BLINK_STEADY: vis = row_hit;
      BLINK_FAST:   vis = row_hit && fast_ph;
      BLINK_SLOW:   vis = row_hit && slow_ph;
      default:      vis = 0;
    endcase
    uline = at[ATTR_ULINE_BIT] && ln == 7;
    blk = at[ATTR_BLINK_BIT] && fast_ph;
    transp = at[ATTR_TRANSP_BIT];
    rev = at[ATTR_REVERSE_BIT];
    if (vis && cl == cur_col) begin
      if (r_shape == CUR_BLOCK) pix = ~pix;
      else if (r_shape == CUR_RIGHT) pix[0] = 1'b1;
      else if (r_shape == CUR_BOTTOM && ln == 7) pix = 8'hFF;
    end else if (blk) begin
      pix = ~pix;
    end
    for (int j = 0; j < 8; j++) begin
      b = uline || pix[7-j];
      o = '0;
      if (!in_range) begin
        o.pixel_color = '0;
      end else if (transp) begin
        if (rev && !b) begin o.pixel_color = bgc; o.opaque = 1; end
        if (!rev && b) begin o.pixel_color = fgc; o.opaque = 1; end
      end else begin
        o.opaque = 1;
        o.pixel_color = (b ^ rev) ? fgc : bgc;
      end
      o.last_pixel = (j == 7);
      pixels_due.push_back(o);
    end
  endfunction

  function automatic void console_step(in_item_t it);
    int cols, rows;
    logic [19:0] wcell;
    cols = used_cols(); rows = used_rows();
    wcell = {r_attr, r_bg, r_fg, it.char_code};
    case (it.command)
      CMD_PUT_CURSOR: begin
        if (cur_row < rows && cur_col < cols) cells[cur_row*NCOLS + cur_col] = wcell;
        cur_col++;
        if (cur_col >= cols) begin
          cur_col = 0;
          cur_row++;
          if (cur_row >= rows) cur_row = 0;
        end
      end
      CMD_PUT_AT:
        if (it.text_row < rows && it.text_col < cols)
          cells[it.text_row*NCOLS + it.text_col] = wcell;
      CMD_MOVE: begin
        cur_col = (it.text_col >= cols) ? cols - 1 : it.text_col;
        cur_row = (it.text_row >= rows) ? rows - 1 : it.text_row;
      end
      CMD_RENDER: render_slice(it);
      CMD_FONT: glyphs[it.table_index] = it.table_data[7:0];
      CMD_PALETTE: if (it.table_index < 16) colours[it.table_index[3:0]] = it.table_data;
      CMD_TICK: begin
        fast_cnt++;
        if (fast_cnt >= DEF_FAST_BLINK_TICKS) begin fast_cnt = 0; fast_ph = !fast_ph; end
        slow_cnt++;
        if (slow_cnt >= DEF_SLOW_BLINK_TICKS) begin slow_cnt = 0; slow_ph = !slow_ph; end
      end
      CMD_CLEAR:
        for (int r = 0; r < rows; r++)
          for (int c = 0; c < cols; c++) cells[r*NCOLS + c] = BLANK_CELL;
      CMD_SCROLL_UP: begin
        for (int r = 0; r + 1 < rows; r++)
          for (int c = 0; c < cols; c++) cells[r*NCOLS + c] = cells[(r+1)*NCOLS + c];
        for (int c = 0; c < cols; c++) cells[(rows-1)*NCOLS + c] = BLANK_CELL;
      end
      CMD_SCROLL_DOWN: begin
        for (int r = rows - 1; r > 0; r--)
          for (int c = 0; c < cols; c++) cells[r*NCOLS + c] = cells[(r-1)*NCOLS + c];
        for (int c = 0; c < cols; c++) cells[c] = BLANK_CELL;
      end
      default: ;
    endcase
  endfunction

  function automatic void set_register(logic [2:0] idx, logic [7:0] v);
    case (idx)
      CFG_COLUMNS:   r_cols = v;
      CFG_ROWS:      r_rows = v[6:0];
      CFG_CUR_SHAPE: r_shape = v[1:0];
      CFG_CUR_BLINK: r_blink = v[1:0];
      CFG_WR_FG:     r_fg = v[3:0];
      CFG_WR_BG:     r_bg = v[3:0];
      CFG_WR_ATTR:   r_attr = v[3:0];
      default: ;
    endcase
  endfunction

  // ---- stimulus helpers ----
  function automatic void push_cmd(logic [3:0] cmd, int ch, int row, int col,
                                   int line, int idx, int data);
    job_t j;
    j.kind = JOB_ITEM;
    j.item.command = cmd; j.item.char_code = 8'(ch);
    j.item.text_row = 6'(row); j.item.text_col = 7'(col); j.item.char_line = 3'(line);
    j.item.table_index = 11'(idx); j.item.table_data = 16'(data);
    jobs.push_back(j);
  endfunction

  function automatic void push_reg(logic [2:0] idx, int v);
    job_t j;
    j.kind = JOB_CFG; j.reg_idx = idx; j.reg_val = 8'(v); j.item = '0;
    jobs.push_back(j);
  endfunction

  function automatic void push_drain();
    job_t j;
    j.kind = JOB_DRAIN; j.item = '0;
    jobs.push_back(j);
  endfunction

  function automatic logic [7:0] any_char();
    return char_set[$urandom_range(2)];
  endfunction

  function automatic void new_colours();
    push_reg(CFG_WR_FG, $urandom_range(15));
    push_reg(CFG_WR_BG, $urandom_range(15));
    push_reg(CFG_WR_ATTR, $urandom_range(15));
  endfunction

  // random commands aimed mostly at the area in use
  function automatic void random_burst(int n, int rmax, int cmax);
    int p, row, col;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(99);
      if ($urandom_range(9) == 0) begin
        row = $urandom_range(63); col = $urandom_range(127);
      end else begin
        row = $urandom_range(rmax - 1); col = $urandom_range(cmax - 1);
      end
      if (p < 35)
        push_cmd(CMD_RENDER, $urandom_range(255), row, col, $urandom_range(7), 0, 0);
      else if (p < 50)
        push_cmd(CMD_PUT_CURSOR, any_char(), 0, 0, 0, $urandom_range(2047), 0);
      else if (p < 65) push_cmd(CMD_PUT_AT, any_char(), row, col, 0, 0, 0);
      else if (p < 73) push_cmd(CMD_MOVE, $urandom_range(255), row, col, 0, 0, 0);
      else if (p < 78)
        push_cmd(CMD_FONT, 0, 0, 0, 0, {3'($urandom_range(7)), any_char()},
                 $urandom_range(65535));
      else if (p < 84)
        push_cmd(CMD_PALETTE, 0, 0, 0, 0,
                 ($urandom_range(3) == 0) ? $urandom_range(2047) : $urandom_range(15),
                 $urandom_range(65535));
      else if (p < 89) push_cmd(CMD_TICK, 0, 0, 0, 0, 0, 0);
      else if (p < 91) push_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
      else if (p < 94) push_cmd(CMD_SCROLL_UP, 0, 0, 0, 0, 0, 0);
      else if (p < 97) push_cmd(CMD_SCROLL_DOWN, 0, 0, 0, 0, 0, 0);
      else push_cmd(4'($urandom_range(10, 15)), $urandom_range(255), row, col, 0, 0, 0);
    end
  endfunction

  function automatic void tick_run(int n);
    for (int i = 0; i < n; i++) push_cmd(CMD_TICK, 0, 0, 0, 0, 0, 0);
  endfunction

  // ---- driver ----
  always @(negedge clk) begin
    bit nv, ncv;
    job_t j;
    nv = in_valid && !in_acc;
    ncv = cfg_valid && !cfg_acc;
    if (rst_n && !nv && !ncv && jobs.size() > 0) begin
      j = jobs[0];
      case (j.kind)
        JOB_ITEM:
          if (calm || $urandom_range(99) >= 14) begin
            void'(jobs.pop_front());
            in_data <= j.item;
            nv = 1;
          end
        JOB_CFG:
          if (pixels_due.size() == 0 && quiet >= settle) begin
            void'(jobs.pop_front());
            cfg_index <= j.reg_idx;
            cfg_data <= j.reg_val;
            ncv = 1;
          end
        default:
          if (pixels_due.size() == 0) void'(jobs.pop_front());
      endcase
    end
    in_valid <= nv;
    cfg_valid <= ncv;
    out_ready <= calm || $urandom_range(99) >= 14;
  end

  // ---- monitor, predictor update and watchdog ----
  always @(posedge clk) begin
    out_item_t want;
    cyc++;
    in_acc = in_valid && in_ready;
    cfg_acc = cfg_valid && cfg_ready;
    quiet = in_acc ? 0 : quiet + 1;
    if (in_acc) begin
      n_items++;
      if (in_data.command inside {CMD_CLEAR, CMD_SCROLL_UP, CMD_SCROLL_DOWN})
        settle = SETTLE_BULK;
      console_step(in_data);
    end
    if (cfg_acc) begin
      n_cfg++;
      settle = SETTLE_SHORT;
      set_register(cfg_index, cfg_data);
    end
    if (rst_n && out_valid && out_ready) begin
      n_pixels++;
      if (pixels_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected pixel beat %p", out_data);
      end else begin
        want = pixels_due.pop_front();
        if (out_data !== want) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: pixel %0d: colour %h/%h opaque %b/%b last %b/%b (exp/got)",
                     n_pixels, want.pixel_color, out_data.pixel_color, want.opaque,
                     out_data.opaque, want.last_pixel, out_data.last_pixel);
        end
      end
    end
    idle_cnt = (in_acc || cfg_acc || (out_valid && out_ready)) ? 0 : idle_cnt + 1;
    if (idle_cnt >= WATCHDOG) begin
      $display("Timeout: no beat for %0d cycles", WATCHDOG);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NCOLS*NROWS; i++) cells[i] = BLANK_CELL;
    for (int i = 0; i < 2048; i++) glyphs[i] = '0;
    for (int i = 0; i < 16; i++) colours[i] = '0;
    cur_row = 0; cur_col = 0; fast_cnt = 0; slow_cnt = 0; fast_ph = 0; slow_ph = 0;
    r_cols = RST_COLUMNS; r_rows = RST_ROWS; r_shape = CUR_OFF; r_blink = BLINK_STEADY;
    r_fg = RST_WR_FG; r_bg = '0; r_attr = '0;

    // tables first: glyphs for the characters in use, every palette entry
    for (int l = 0; l < 8; l++)
      for (int c = 0; c < 3; c++)
        push_cmd(CMD_FONT, 0, 0, 0, 0, l*256 + char_set[c], $urandom_range(65535));
    for (int k = 0; k < 16; k++) push_cmd(CMD_PALETTE, 0, 0, 0, 0, k, $urandom_range(65535));
    push_cmd(CMD_PALETTE, 0, 0, 0, 0, 2047, 16'hFFFF); // beyond palette, ignored

    // directed part at reset geometry (80 x 60)
    push_reg(CFG_CUR_SHAPE, CUR_BLOCK);
    push_cmd(CMD_RENDER, 0, 0, 0, 0, 0, 0);      // blank transparent cell under cursor
    push_cmd(CMD_PUT_CURSOR, 8'hFF, 0, 0, 0, 0, 0);
    push_cmd(CMD_PUT_AT, 8'h5A, 0, 79, 0, 0, 0);
    push_cmd(CMD_PUT_AT, 8'hFF, 60, 0, 0, 0, 0);  // out of range, dropped
    push_cmd(CMD_PUT_AT, 8'hFF, 63, 127, 0, 0, 0);
    push_cmd(CMD_MOVE, 0, 63, 127, 0, 0, 0);     // clamps to last cell
    push_cmd(CMD_PUT_CURSOR, 8'h5A, 0, 0, 0, 0, 0); // wraps to the top
    push_cmd(CMD_RENDER, 0, 0, 0, 7, 0, 0);
    push_cmd(CMD_RENDER, 0, 0, 79, 7, 0, 0);
    push_cmd(CMD_RENDER, 0, 63, 127, 3, 0, 0);   // outside area in use
    push_cmd(CMD_RENDER, 0, 59, 79, 0, 0, 0);
    push_cmd(4'd15, 8'hFF, 63, 127, 7, 2047, 65535);
    push_cmd(CMD_SCROLL_DOWN, 0, 0, 0, 0, 0, 0);
    push_cmd(CMD_RENDER, 0, 1, 0, 2, 0, 0);
    push_cmd(CMD_SCROLL_UP, 0, 0, 0, 0, 0, 0);
    push_cmd(CMD_RENDER, 0, 0, 79, 5, 0, 0);
    push_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
    push_cmd(CMD_RENDER, 0, 0, 79, 5, 0, 0);
    push_drain(); // sender holds off until all pixels are back

    // small window
    push_reg(CFG_COLUMNS, 4); push_reg(CFG_ROWS, 3); push_reg(CFG_CUR_SHAPE, CUR_RIGHT);
    new_colours();
    random_burst(12, 3, 4);
    // zero geometry acts as a single cell
    push_reg(CFG_COLUMNS, 0); push_reg(CFG_ROWS, 0); push_reg(CFG_CUR_SHAPE, CUR_BOTTOM);
    push_reg(CFG_WR_ATTR, 15);
    random_burst(5, 1, 1);
    // oversized geometry clamps to the maximum; hidden cursor
    push_reg(CFG_COLUMNS, 255); push_reg(CFG_ROWS, 127); push_reg(CFG_CUR_SHAPE, CUR_BLOCK);
    push_reg(CFG_CUR_BLINK, 3);
    new_colours();
    random_burst(8, 64, 128);
    // blink modes
    push_reg(CFG_COLUMNS, 8); push_reg(CFG_ROWS, 8); push_reg(CFG_CUR_BLINK, BLINK_FAST);
    push_reg(CFG_WR_ATTR, 1);
    tick_run(3);
    random_burst(8, 8, 8);
    push_reg(CFG_CUR_BLINK, BLINK_SLOW); push_reg(CFG_COLUMNS, 128); push_reg(CFG_ROWS, 64);
    new_colours();
    random_burst(6, 8, 8);
    push_reg(CFG_CUR_BLINK, BLINK_STEADY); push_reg(CFG_CUR_SHAPE, CUR_OFF);
    new_colours();
    random_burst(8, 6, 10);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    wait (jobs.size() == 0 && !in_valid && !cfg_valid && pixels_due.size() == 0);
    repeat (SETTLE_BULK) @(posedge clk);
    if (pixels_due.size() != 0) begin
      errors++;
      $display("ERROR: %0d pixels never arrived", pixels_due.size());
    end
    $display("Covered %0d commands, %0d register writes, %0d pixels checked,",
             n_items, n_cfg, n_pixels);
    $display("over several geometries, cursor shapes, blink modes and scrolls.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Mismatches: %0d", errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
